>>> src/uhb_pkg.sv
package uhb_pkg;

    localparam int MAX_BINS   = 256;
    localparam int COUNT_BITS = 32;
    localparam int BIN_AW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int COUNT_XW   = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    localparam int SAMPLE_W   = 16;
    localparam int SEL_W      = 8;
    localparam int INDEX_W    = 8;
    localparam int OCOUNT_W   = 32;
    localparam int INV_W      = 24;
    localparam int BINS_W     = 9;
    localparam int PROD_W     = SAMPLE_W + INV_W;
    localparam int FRAC_BITS  = 16;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_BIN,
        ST_RMW
    } uhb_state_t;

endpackage

>>> src/uhb_ram.sv
module uhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/uniform_histogram_binner_core.sv
// Uniform-bin histogram core.
// Input stream (s_*): s_tuser is the item kind (0 = add sample, 1 = read and
// clear a bin); s_tdata carries sample_value and bin_select. A sample lands in
// bin ((sample - range_min) * inv_width) >> 16, clamped to the last bin in use;
// samples outside [range_min, range_max] come back with dropped set.
// Output stream (m_*): one transfer per input item with bin_index, bin_count
// and the dropped flag in m_tuser.
// Configuration port (cfg_*): always ready; write only while the core is idle.
// Each item walks a four-step sequence over the counter memory: capture,
// multiply, address and read, then modify and write back. The input is only
// ready in the capture step, so a new item is taken only once the previous
// one has finished its write-back.
// A result held in the output register does not block the next item; the
// sequence only waits in its write-back step while the output register is
// still full and m_tready is low.
// Reset (rst_n low) restores the register defaults and clears all counts at
// once through per-bin valid flags; no clearing pass is needed.
module uniform_histogram_binner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uhb_pkg::S_TDATA_W-1:0]   s_tdata,   // sample_value[15:0], bin_select[23:16]
    input  logic                            s_tuser,   // kind[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uhb_pkg::M_TDATA_W-1:0]   m_tdata,   // bin_index[7:0], bin_count[39:8]
    output logic                            m_tuser,   // dropped[0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uhb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uhb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import uhb_pkg::*;

    uhb_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] range_min_reg, range_max_reg;
    logic [INV_W-1:0]           inv_width_reg;
    logic [BINS_W-1:0]          bins_in_use_reg;

    logic                  kind_reg, kind_next;
    logic [SEL_W-1:0]      sel_reg, sel_next;
    logic                  drop_reg, drop_next;
    logic                  at_max_reg, at_max_next;
    logic [SAMPLE_W-1:0]   diff_reg, diff_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [BIN_AW-1:0]     addr_reg, addr_next;
    logic                  sel_ok_reg, sel_ok_next;
    logic [MAX_BINS-1:0]   valid_reg, valid_next;

    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]    m_index_reg, m_index_next;
    logic [OCOUNT_W-1:0]   m_count_reg, m_count_next;
    logic                  m_drop_reg, m_drop_next;

    logic                  in_xfer, out_free;
    logic                  rd_en, wr_en;
    logic [COUNT_BITS-1:0] rd_data, cur_count, new_count;
    logic [COUNT_XW-1:0]   count_x;
    logic signed [SAMPLE_W:0] s_ext, rmin_ext, diff_full;
    logic signed [SAMPLE_W-1:0] s_in;
    logic [PROD_W-FRAC_BITS-1:0] bin_raw;
    logic [31:0]           last32;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= -16'sd32768;
            range_max_reg   <= 16'sd32767;
            inv_width_reg   <= INV_W'(256);
            bins_in_use_reg <= BINS_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RANGE_MIN:   range_min_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_RANGE_MAX:   range_max_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_INV_WIDTH:   inv_width_reg   <= cfg_data[INV_W-1:0];
                CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = in_xfer ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_BIN;
            ST_BIN:  state_next = ST_RMW;
            ST_RMW:  state_next = out_free ? ST_IDLE : ST_RMW;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_MUL:  ;
            ST_BIN:  rd_en = 1'b1;
            ST_RMW:  wr_en = out_free && (kind_reg == KIND_SAMPLE) && !drop_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        s_in      = s_tdata[SAMPLE_W-1:0];
        s_ext     = {s_in[SAMPLE_W-1], s_in};
        rmin_ext  = {range_min_reg[SAMPLE_W-1], range_min_reg};
        diff_full = s_ext - rmin_ext;

        kind_next   = kind_reg;
        sel_next    = sel_reg;
        drop_next   = drop_reg;
        at_max_next = at_max_reg;
        diff_next   = diff_reg;
        if (in_xfer)
        begin
            kind_next   = s_tuser;
            sel_next    = s_tdata[SAMPLE_W+SEL_W-1:SAMPLE_W];
            drop_next   = (s_tuser == KIND_SAMPLE)
                          && ((s_in < range_min_reg) || (s_in > range_max_reg));
            at_max_next = (s_in == range_max_reg);
            diff_next   = diff_full[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        prod_next = prod_reg;
        if (state_reg == ST_MUL)
        begin
            prod_next = PROD_W'(diff_reg) * PROD_W'(inv_width_reg);
        end
    end

    always_comb
    begin
        bin_raw = prod_reg[PROD_W-1:FRAC_BITS];
        if (bins_in_use_reg == '0)
        begin
            last32 = 32'd0;
        end
        else if (32'(bins_in_use_reg) > 32'(MAX_BINS))
        begin
            last32 = 32'(MAX_BINS - 1);
        end
        else
        begin
            last32 = 32'(bins_in_use_reg) - 32'd1;
        end

        addr_next   = addr_reg;
        sel_ok_next = sel_ok_reg;
        if (state_reg == ST_BIN)
        begin
            sel_ok_next = (32'(sel_reg) < 32'(MAX_BINS));
            if (kind_reg == KIND_READ)
            begin
                addr_next = BIN_AW'(sel_reg);
            end
            else if (at_max_reg || (32'(bin_raw) > last32))
            begin
                addr_next = BIN_AW'(last32);
            end
            else
            begin
                addr_next = BIN_AW'(bin_raw);
            end
        end
    end

    uhb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (new_count),
        .rd_en   (rd_en),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cur_count = valid_reg[addr_reg] ? rd_data : '0;
        new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);

        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_count_next = m_count_reg;
        m_drop_next  = m_drop_reg;
        count_x      = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if ((state_reg == ST_RMW) && out_free)
        begin
            m_valid_next = 1'b1;
            m_drop_next  = 1'b0;
            if (kind_reg == KIND_READ)
            begin
                m_index_next = sel_reg;
                if (sel_ok_reg)
                begin
                    count_x              = COUNT_XW'(cur_count);
                    valid_next[addr_reg] = 1'b0;
                end
                m_count_next = count_x[OCOUNT_W-1:0];
            end
            else if (drop_reg)
            begin
                m_index_next = '0;
                m_count_next = '0;
                m_drop_next  = 1'b1;
            end
            else
            begin
                count_x              = COUNT_XW'(new_count);
                valid_next[addr_reg] = 1'b1;
                m_index_next         = INDEX_W'(addr_reg);
                m_count_next         = count_x[OCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        sel_reg     <= sel_next;
        drop_reg    <= drop_next;
        at_max_reg  <= at_max_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        addr_reg    <= addr_next;
        sel_ok_reg  <= sel_ok_next;
        m_index_reg <= m_index_next;
        m_count_reg <= m_count_next;
        m_drop_reg  <= m_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_index_reg};
    assign m_tuser  = m_drop_reg;

endmodule

>>> tb/tb_uniform_histogram_binner_core.sv
`timescale 1ns / 1ps

module tb_uniform_histogram_binner_core;

    import uhb_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic [OCOUNT_W-1:0] cnt;
        logic                drop;
    } bin_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow of the configuration and the counter store
    int                     lo_limit = -32768;
    int                     hi_limit = 32767;
    logic [INV_W-1:0]       inv_step = 24'd256;
    logic [BINS_W-1:0]      bins_set = 9'd256;
    logic [COUNT_BITS-1:0]  bin_tally [MAX_BINS];

    bin_result_t            expected_bins [$];
    int                     error_count = 0;
    int                     gap_odds = 0;
    int                     stall_odds = 0;
    int                     stall_left = 0;
    int                     quiet_cycles = 0;

    uniform_histogram_binner_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
        error_count++;
    endtask

    function automatic int bins_active();
        if (bins_set == 0)
            return 1;
        if (bins_set > MAX_BINS)
            return MAX_BINS;
        return int'(bins_set);
    endfunction

    function automatic bin_result_t histogram_update(input logic kind, input logic [15:0] smp,
                                                     input logic [7:0] sel);
        bin_result_t      r;
        int               s;
        int               nb;
        longint unsigned  slot;
        r = '0;
        if (kind == KIND_SAMPLE)
        begin
            s = int'($signed(smp));
            if (s < lo_limit || s > hi_limit)
            begin
                r.drop = 1'b1;
            end
            else
            begin
                nb = bins_active();
                slot = longint'(s - lo_limit);
                slot = (slot * 64'(inv_step)) >> FRAC_BITS;
                if (s == hi_limit || slot >= longint'(nb))
                    slot = longint'(nb - 1);
                if (bin_tally[slot] != '1)
                    bin_tally[slot] = bin_tally[slot] + COUNT_BITS'(1);
                r.idx = slot[INDEX_W-1:0];
                r.cnt = bin_tally[slot][OCOUNT_W-1:0];
            end
        end
        else
        begin
            r.idx = sel;
            r.cnt = bin_tally[sel][OCOUNT_W-1:0];
            bin_tally[sel] = '0;
        end
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [15:0] smp, input logic [7:0] sel);
        logic [S_TDATA_W-1:0] word;
        word = S_TDATA_W'($urandom);
        if (kind == KIND_SAMPLE)
            word[15:0] = smp;
        else
            word[23:16] = sel;
        if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        expected_bins.push_back(histogram_update(kind, word[15:0], word[23:16]));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RANGE_MIN:   lo_limit = int'($signed(data[15:0]));
            CFG_RANGE_MAX:   hi_limit = int'($signed(data[15:0]));
            CFG_INV_WIDTH:   inv_step = data[INV_W-1:0];
            CFG_BINS_IN_USE: bins_set = data[BINS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int lo, input int hi, input int inv, input int nb);
        logic [15:0] lo16;
        logic [15:0] hi16;
        lo16 = lo[15:0];
        hi16 = hi[15:0];
        wait_idle();
        write_reg(CFG_RANGE_MIN, {8'h00, lo16});
        write_reg(CFG_RANGE_MAX, {8'h00, hi16});
        write_reg(CFG_INV_WIDTH, inv[INV_W-1:0]);
        write_reg(CFG_BINS_IN_USE, {15'h0000, nb[BINS_W-1:0]});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        int lo;
        int hi;
        int nb;
        int span;
        int inv;
        lo = $urandom_range(0, 65535) - 32768;
        hi = $urandom_range(0, 65535) - 32768;
        if (lo > hi)
        begin
            span = lo;
            lo = hi;
            hi = span;
        end
        nb = $urandom_range(1, MAX_BINS);
        case ($urandom_range(0, 5))
            0:
            begin
                lo = -32768;
                hi = 32767;
                nb = MAX_BINS;
            end
            2:
            begin
                hi = lo + $urandom_range(0, 40);
                if (hi > 32767)
                    hi = 32767;
                nb = $urandom_range(1, 8);
            end
            3:
            begin
                span = lo;
                lo = hi + 1 + $urandom_range(0, 50);
                if (lo > 32767)
                    lo = 32767;
                hi = span;
                if (hi >= lo)
                    hi = lo - 1;
            end
            4: nb = $urandom_range(0, 511);
            5: nb = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
            default: ;
        endcase
        span = (hi >= lo) ? hi - lo + 1 : 1;
        inv = int'((longint'(nb == 0 ? 1 : nb) << FRAC_BITS) / span);
        case ($urandom_range(0, 7))
            0: inv = 0;
            1: inv = 24'hFFFFFF;
            2: inv = $urandom_range(1, 24'hFFFFFF);
            3: inv = inv + $urandom_range(0, 3000);
            default: ;
        endcase
        if (inv > 24'hFFFFFF)
            inv = 24'hFFFFFF;
        configure(lo, hi, inv, nb);
    endtask

    task automatic random_item();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 60 && lo_limit <= hi_limit)
        begin
            v = lo_limit + $urandom_range(0, hi_limit - lo_limit);
            send_item(KIND_SAMPLE, v[15:0], 8'h00);
        end
        else if (pick < 72)
        begin
            case ($urandom_range(0, 3))
                0: v = lo_limit;
                1: v = hi_limit;
                2: v = lo_limit - 1;
                default: v = hi_limit + 1;
            endcase
            send_item(KIND_SAMPLE, v[15:0], 8'h00);
        end
        else if (pick < 82)
        begin
            send_item(KIND_SAMPLE, 16'($urandom), 8'h00);
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            v = $urandom_range(0, bins_active() - 1);
            send_item(KIND_READ, 16'h0000, v[7:0]);
        end
        else
        begin
            send_item(KIND_READ, 16'h0000, 8'($urandom));
        end
    endtask

    task automatic test_default_config();
        send_item(KIND_SAMPLE, 16'h8000, 8'h00);
        send_item(KIND_SAMPLE, 16'h7FFF, 8'h00);
        send_item(KIND_SAMPLE, 16'h0000, 8'h00);
        send_item(KIND_SAMPLE, 16'h0000, 8'h00);
        send_item(KIND_SAMPLE, 16'hFFFF, 8'h00);
        send_item(KIND_READ, 16'h0000, 8'd128);
        send_item(KIND_READ, 16'h0000, 8'd128);
        send_item(KIND_READ, 16'hFFFF, 8'd255);
    endtask

    task automatic test_range_edges();
        configure(-100, 100, 3260, 10);
        send_item(KIND_SAMPLE, 16'hFF9B, 8'h00);
        send_item(KIND_SAMPLE, 16'd101, 8'h00);
        send_item(KIND_SAMPLE, 16'hFF9C, 8'h00);
        send_item(KIND_SAMPLE, 16'd100, 8'h00);
        send_item(KIND_SAMPLE, 16'h7FFF, 8'h00);
        send_item(KIND_SAMPLE, 16'h8000, 8'h00);
    endtask

    task automatic test_odd_settings();
        // zero reciprocal, zero bins
        configure(-5, 5, 0, 0);
        send_item(KIND_SAMPLE, 16'hFFFB, 8'h00);
        send_item(KIND_SAMPLE, 16'd5, 8'h00);
        // widest reciprocal overshoots, bins above the store size
        configure(0, 1000, 24'hFFFFFF, 511);
        send_item(KIND_SAMPLE, 16'd0, 8'h00);
        send_item(KIND_SAMPLE, 16'd1, 8'h00);
        // inverted range drops everything
        configure(10, -10, 256, 1);
        send_item(KIND_SAMPLE, 16'd0, 8'h00);
        send_item(KIND_SAMPLE, 16'd10, 8'h00);
        // single-value range lands in the last bin
        configure(7, 7, 256, 256);
        send_item(KIND_SAMPLE, 16'd7, 8'h00);
        send_item(KIND_READ, 16'h0000, 8'd255);
        send_item(KIND_READ, 16'h0000, 8'd0);
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 7; phase++)
        begin
            random_config();
            gap_odds   = (phase % 3 == 0) ? 0 : 3 + 3 * (phase % 2);
            stall_odds = (phase % 3 == 1) ? 0 : 3 + 2 * (phase % 2);
            for (int n = 0; n < 215; n++)
                random_item();
        end
    endtask

    task automatic test_pause_until_drained();
        configure(-1000, 1000, 65, 32);
        gap_odds = 4;
        stall_odds = 4;
        for (int n = 0; n < 40; n++)
            random_item();
        wait_idle();
        for (int n = 0; n < 40; n++)
            random_item();
    endtask

    task automatic test_back_to_back();
        configure(-20, 20, 13000, 8);
        gap_odds = 0;
        stall_odds = 0;
        for (int n = 0; n < 200; n++)
            random_item();
        for (int b = 0; b < 8; b++)
            send_item(KIND_READ, 16'h0000, b[7:0]);
    endtask

    always @(posedge clk)
    begin : result_check
        bin_result_t want;
        bin_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.idx  = m_tdata[7:0];
            got.cnt  = m_tdata[39:8];
            got.drop = m_tuser;
            if (expected_bins.size() == 0)
            begin
                report_mismatch("unexpected result bin_index", -1, got.idx);
            end
            else
            begin
                want = expected_bins.pop_front();
                if (got.idx !== want.idx)
                    report_mismatch("bin_index", want.idx, got.idx);
                if (got.cnt !== want.cnt)
                    report_mismatch("bin_count", want.cnt, got.cnt);
                if (got.drop !== want.drop)
                    report_mismatch("dropped", want.drop, got.drop);
            end
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(stall_odds - 1) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int b = 0; b < MAX_BINS; b++)
            bin_tally[b] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_range_edges();
        test_odd_settings();
        test_random_mix();
        test_pause_until_drained();
        test_back_to_back();
        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_bins.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
